FILE: rtl/rhkv_pkg.sv
// Shared types, constants and codes for the Robin Hood key/value map.
package rhkv_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = AW + 1;
  localparam int HASH_SHIFT = 32 - AW;
  // The home slot only depends on the low 32 product bits, so only the
  // low word of the multiplier matters.
  localparam logic [31:0] HASH_MULT_LO = 32'(64'd990590075063);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] probe_dist;
    logic [31:0]   value;
    logic [63:0]   key;
  } slot_t;

endpackage

FILE: rtl/robin_hood_key_value_map_unit.sv
// Robin Hood key/value map: one slot memory and a probing sequencer.
// Unused kinds and inserts into a full table are answered from idle without probing;
// other items go through hash, home, then read and evaluate for each slot visited.
// One item at a time: a probing item holds busy high until its result is ready.
// Reset: a clearing pass writes all TABLE_SIZE (1024) slots with busy high.
// The receiver cannot stall: each result shows for one cycle on out_valid.
module robin_hood_key_value_map_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_key,
  input  logic [31:0] in_entry_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_value,
  output logic [10:0] out_occupancy
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_HOME  = 6'b001000,
    S_RD    = 6'b010000,
    S_EV    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        shift_r, shift_nxt;
  logic [63:0] ck_r, ck_nxt;
  logic [31:0] cv_r, cv_nxt;
  logic [rhkv_pkg::AW-1:0] cd_r, cd_nxt;
  logic [rhkv_pkg::AW-1:0] idx_r, idx_nxt;
  logic [rhkv_pkg::AW-1:0] prev_r, prev_nxt;
  logic [rhkv_pkg::CW-1:0] n_r, n_nxt;
  logic [rhkv_pkg::CW-1:0] clr_r, clr_nxt;
  logic [10:0] count_r, count_nxt;
  logic [31:0] prod_r;
  logic        ov_r, ov_nxt;
  logic [2:0]  os_r, os_nxt;
  logic [31:0] ofv_r, ofv_nxt;

  rhkv_pkg::slot_t mem [rhkv_pkg::TABLE_SIZE];
  rhkv_pkg::slot_t rdata_r, wdata;
  logic we;
  logic [rhkv_pkg::AW-1:0] waddr, idx_inc;
  logic [31:0] h_lo;
  logic probe_end;

  assign h_lo = ck_r[31:0] ^ ck_r[rhkv_pkg::HASH_SHIFT +: 32];
  assign idx_inc = (idx_r == rhkv_pkg::AW'(rhkv_pkg::TABLE_SIZE - 1)) ?
                   '0 : idx_r + 1'b1;
  assign probe_end = (n_r == rhkv_pkg::CW'(rhkv_pkg::TABLE_SIZE)) || !rdata_r.valid;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[idx_r];
    prod_r  <= h_lo * rhkv_pkg::HASH_MULT_LO;
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    shift_nxt = shift_r;
    ck_nxt    = ck_r;
    cv_nxt    = cv_r;
    cd_nxt    = cd_r;
    idx_nxt   = idx_r;
    prev_nxt  = prev_r;
    n_nxt     = n_r;
    clr_nxt   = clr_r;
    count_nxt = count_r;
    ov_nxt    = 1'b0;
    os_nxt    = os_r;
    ofv_nxt   = ofv_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = '{valid: 1'b1, probe_dist: cd_r, value: cv_r, key: ck_r};
    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r[rhkv_pkg::AW-1:0];
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == rhkv_pkg::CW'(rhkv_pkg::TABLE_SIZE - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          ck_nxt    = in_key;
          cv_nxt    = in_entry_value;
          shift_nxt = 1'b0;
          ofv_nxt   = '0;
          if (in_kind != rhkv_pkg::KIND_INSERT && in_kind != rhkv_pkg::KIND_LOOKUP &&
              in_kind != rhkv_pkg::KIND_REMOVE) begin
            ov_nxt = 1'b1;
            os_nxt = rhkv_pkg::ST_NOT_FOUND;
          end else if (in_kind == rhkv_pkg::KIND_INSERT &&
                       count_r >= 11'(rhkv_pkg::TABLE_SIZE)) begin
            ov_nxt = 1'b1;
            os_nxt = rhkv_pkg::ST_FULL;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: state_nxt = S_HOME;
      S_HOME: begin
        idx_nxt   = prod_r[rhkv_pkg::HASH_SHIFT +: rhkv_pkg::AW];
        n_nxt     = '0;
        cd_nxt    = '0;
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        state_nxt = S_RD;
        idx_nxt   = idx_inc;
        n_nxt     = n_r + 1'b1;
        if (shift_r) begin
          // Backward shift: pull the following entry one slot toward home.
          if (!probe_end && rdata_r.probe_dist != '0) begin
            we    = 1'b1;
            waddr = prev_r;
            wdata = '{valid: 1'b1, probe_dist: rdata_r.probe_dist - 1'b1,
                      value: rdata_r.value, key: rdata_r.key};
            prev_nxt = idx_r;
          end else begin
            we        = 1'b1;
            waddr     = prev_r;
            wdata     = '0;
            count_nxt = count_r - 1'b1;
            ov_nxt    = 1'b1;
            os_nxt    = rhkv_pkg::ST_FOUND;
            state_nxt = S_IDLE;
          end
        end else if (kind_r == rhkv_pkg::KIND_INSERT) begin
          if (probe_end) begin
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
            ov_nxt    = 1'b1;
            os_nxt    = rhkv_pkg::ST_INSERTED;
            state_nxt = S_IDLE;
          end else if (rdata_r.key == ck_r) begin
            we        = 1'b1;
            wdata     = '{valid: 1'b1, probe_dist: rdata_r.probe_dist, value: cv_r,
                          key: ck_r};
            ov_nxt    = 1'b1;
            os_nxt    = rhkv_pkg::ST_UPDATED;
            state_nxt = S_IDLE;
          end else if (cd_r > rdata_r.probe_dist) begin
            // The carried entry is poorer: it takes the slot, the resident moves on.
            we     = 1'b1;
            ck_nxt = rdata_r.key;
            cv_nxt = rdata_r.value;
            cd_nxt = rdata_r.probe_dist + 1'b1;
          end else begin
            cd_nxt = cd_r + 1'b1;
          end
        end else begin
          if (probe_end) begin
            ov_nxt    = 1'b1;
            os_nxt    = rhkv_pkg::ST_NOT_FOUND;
            state_nxt = S_IDLE;
          end else if (rdata_r.key == ck_r) begin
            if (kind_r == rhkv_pkg::KIND_LOOKUP) begin
              ov_nxt    = 1'b1;
              os_nxt    = rhkv_pkg::ST_FOUND;
              ofv_nxt   = rdata_r.value;
              state_nxt = S_IDLE;
            end else begin
              shift_nxt = 1'b1;
              prev_nxt  = idx_r;
              n_nxt     = rhkv_pkg::CW'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    ck_r   <= ck_nxt;
    cv_r   <= cv_nxt;
    cd_r   <= cd_nxt;
    idx_r  <= idx_nxt;
    prev_r <= prev_nxt;
    n_r    <= n_nxt;
    os_r   <= os_nxt;
    ofv_r  <= ofv_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_found_value = ofv_r;
  assign out_occupancy   = count_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= 11'(rhkv_pkg::TABLE_SIZE))
    else $error("occupancy above table size");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= rhkv_pkg::ST_FULL)
    else $error("undefined status code");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == rhkv_pkg::KIND_LOOKUP) |=> busy)
    else $error("lookup did not start probing");

  a_fv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rhkv_pkg::ST_FOUND) |-> out_found_value == '0)
    else $error("found value nonzero without hit");

endmodule

FILE: tb/robin_hood_key_value_map_unit_tb.sv
// Self-checking testbench for the Robin Hood key/value map unit.
`timescale 1ns / 1ps

module robin_hood_key_value_map_unit_tb;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [31:0] val;
  } map_op_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [10:0] occupancy;
  } map_reply_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [63:0] in_key;
  logic [31:0] in_entry_value;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_found_value;
  logic [10:0] out_occupancy;

  robin_hood_key_value_map_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_key(in_key), .in_entry_value(in_entry_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_found_value(out_found_value), .out_occupancy(out_occupancy)
  );

  // Shadow copy of the table.
  bit          sh_valid [rhkv_pkg::TABLE_SIZE];
  logic [63:0] sh_key   [rhkv_pkg::TABLE_SIZE];
  logic [31:0] sh_val   [rhkv_pkg::TABLE_SIZE];
  int          sh_dist  [rhkv_pkg::TABLE_SIZE];
  int          sh_count = 0;

  map_op_t    pending_ops[$];
  map_reply_t expected_replies[$];
  logic [63:0] key_pool[$];
  int errors = 0;

  function automatic int home_of(logic [63:0] k);
    logic [63:0] h;
    h = k ^ (k >> rhkv_pkg::HASH_SHIFT);
    h = h * 64'd990590075063;
    return int'((h >> rhkv_pkg::HASH_SHIFT) % rhkv_pkg::TABLE_SIZE);
  endfunction

  function automatic int locate(logic [63:0] k);
    int i;
    i = home_of(k);
    for (int n = 0; n < rhkv_pkg::TABLE_SIZE && sh_valid[i]; n++) begin
      if (sh_key[i] == k) return i;
      i = (i + 1) % rhkv_pkg::TABLE_SIZE;
    end
    return -1;
  endfunction

  function automatic map_reply_t apply_op(map_op_t op);
    map_reply_t r;
    logic [63:0] k, tk;
    logic [31:0] v, tv;
    int i, d, td, s, prev;
    bit done;
    r.status = rhkv_pkg::ST_NOT_FOUND;
    r.found_value = '0;
    k = op.key;
    v = op.val;
    case (op.kind)
      rhkv_pkg::KIND_INSERT: begin
        if (sh_count >= rhkv_pkg::TABLE_SIZE) begin
          r.status = rhkv_pkg::ST_FULL;
        end else begin
          i = home_of(k);
          d = 0;
          done = 0;
          for (int n = 0; n < rhkv_pkg::TABLE_SIZE && sh_valid[i] && !done; n++) begin
            if (sh_key[i] == k) begin
              sh_val[i] = v;
              r.status = rhkv_pkg::ST_UPDATED;
              done = 1;
            end else begin
              // The carried entry takes the slot of a richer resident.
              if (d > sh_dist[i]) begin
                tk = sh_key[i]; tv = sh_val[i]; td = sh_dist[i];
                sh_key[i] = k; sh_val[i] = v; sh_dist[i] = d;
                k = tk; v = tv; d = td;
              end
              d++;
              i = (i + 1) % rhkv_pkg::TABLE_SIZE;
            end
          end
          if (!done) begin
            sh_valid[i] = 1; sh_key[i] = k; sh_val[i] = v; sh_dist[i] = d;
            sh_count++;
            r.status = rhkv_pkg::ST_INSERTED;
          end
        end
      end
      rhkv_pkg::KIND_LOOKUP: begin
        s = locate(k);
        if (s >= 0) begin
          r.status = rhkv_pkg::ST_FOUND;
          r.found_value = sh_val[s];
        end
      end
      rhkv_pkg::KIND_REMOVE: begin
        prev = locate(k);
        if (prev >= 0) begin
          i = (prev + 1) % rhkv_pkg::TABLE_SIZE;
          for (int n = 1; n < rhkv_pkg::TABLE_SIZE && sh_valid[i] && sh_dist[i] > 0;
               n++) begin
            sh_key[prev] = sh_key[i]; sh_val[prev] = sh_val[i];
            sh_dist[prev] = sh_dist[i] - 1;
            prev = i;
            i = (i + 1) % rhkv_pkg::TABLE_SIZE;
          end
          sh_valid[prev] = 0;
          if (sh_count > 0) sh_count--;
          r.status = rhkv_pkg::ST_FOUND;
        end
      end
      default: ;
    endcase
    r.occupancy = 11'(sh_count);
    return r;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Keys mostly come from a small pool so hits, updates and removes happen.
  function automatic logic [63:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return rand_key();
  endfunction

  task automatic push_op(logic [1:0] kind, logic [63:0] key, logic [31:0] val);
    map_op_t op;
    op.kind = kind; op.key = key; op.val = val;
    pending_ops.push_back(op);
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Driver: bursts of items with random gaps in between.
  int burst_left, gap_left;
  map_op_t cur;
  logic busy_at_edge;
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_kind <= rhkv_pkg::KIND_INSERT;
      in_key <= '0;
      in_entry_value <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (start && !busy_at_edge) begin
      // Previous item was taken at the last rising edge.
      start <= 0;
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() > 0) begin
        cur = pending_ops.pop_front();
        in_kind <= cur.kind;
        in_key <= cur.key;
        in_entry_value <= cur.val;
        start <= 1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Acceptance is recorded at the rising edge and the prediction is made there.
  always @(posedge clk) begin
    busy_at_edge <= 1;
    if (rst_n && start && !busy) begin
      expected_replies.push_back(apply_op(map_op_t'{in_kind, in_key, in_entry_value}));
      busy_at_edge <= 0;
    end
  end

  // Monitor: the receiver always takes results.
  always @(posedge clk) begin
    map_reply_t e;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        $error("result with no expectation waiting: status %0d", out_status);
        errors++;
      end else begin
        e = expected_replies.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          errors++;
        end
        if (out_found_value !== e.found_value) begin
          $error("found_value: expected %0h, actual %0h", e.found_value, out_found_value);
          errors++;
        end
        if (out_occupancy !== e.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", e.occupancy, out_occupancy);
          errors++;
        end
      end
    end
  end

  initial begin
    #150_000_000;
    $display("robin_hood_key_value_map_unit regression: fail");
    $finish;
  end

  initial begin
    logic [63:0] k;
    int r, pass;
    rst_n = 0;

    // Directed: extreme keys and values, every kind, the unused kind,
    // a missing remove, an update, and a key pair that collides at home.
    push_op(rhkv_pkg::KIND_LOOKUP, '0, '0);
    push_op(rhkv_pkg::KIND_REMOVE, 64'd5, '0);
    push_op(rhkv_pkg::KIND_INSERT, '1, '1);
    push_op(rhkv_pkg::KIND_INSERT, '0, '0);
    push_op(rhkv_pkg::KIND_LOOKUP, '1, '0);
    push_op(rhkv_pkg::KIND_INSERT, '1, 32'h1234_5678);
    push_op(rhkv_pkg::KIND_LOOKUP, '1, '1);
    push_op(rhkv_pkg::KIND_UNUSED, '1, '1);
    push_op(rhkv_pkg::KIND_INSERT, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
    push_op(rhkv_pkg::KIND_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
    for (int j = 0; j < 4; j++) push_op(rhkv_pkg::KIND_INSERT, 64'(j) << 10, 32'(j));
    push_op(rhkv_pkg::KIND_REMOVE, 64'd0, '0);
    push_op(rhkv_pkg::KIND_LOOKUP, 64'd1 << 10, '0);
    push_op(rhkv_pkg::KIND_REMOVE, '1, '0);
    push_op(rhkv_pkg::KIND_REMOVE, '1, '0);
    push_op(rhkv_pkg::KIND_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, '0);

    // Random mix over a small key pool.
    for (int j = 0; j < 24; j++) key_pool.push_back(rand_key());
    for (int j = 0; j < 450; j++) begin
      r = $urandom_range(0, 9);
      k = pick_key();
      if (r < 5) push_op(rhkv_pkg::KIND_INSERT, k, $urandom());
      else if (r < 7) push_op(rhkv_pkg::KIND_LOOKUP, k, $urandom());
      else if (r < 9) push_op(rhkv_pkg::KIND_REMOVE, k, $urandom());
      else push_op(2'($urandom_range(0, 3)), k, $urandom());
      if ($urandom_range(0, 40) == 0) key_pool[$urandom_range(0, 23)] = rand_key();
    end
    // Fill the table to full, hit it when full, then drain part of it.
    for (int j = 0; j < rhkv_pkg::TABLE_SIZE; j++)
      push_op(rhkv_pkg::KIND_INSERT, 64'(j) * 64'd7919, $urandom());
    push_op(rhkv_pkg::KIND_INSERT, rand_key(), '1);
    push_op(rhkv_pkg::KIND_INSERT, 64'd7919, '1);
    push_op(rhkv_pkg::KIND_LOOKUP, rand_key(), '0);
    push_op(rhkv_pkg::KIND_REMOVE, rand_key(), '0);
    for (int j = 0; j < 200; j++)
      push_op(rhkv_pkg::KIND_REMOVE, 64'($urandom_range(0, 1023)) * 64'd7919, '0);
    for (int j = 0; j < 100; j++)
      push_op(rhkv_pkg::KIND_LOOKUP, 64'($urandom_range(0, 1023)) * 64'd7919, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1;

    wait (pending_ops.size() == 0 && !start);
    pass = 0;
    while (expected_replies.size() != 0 && pass < 100000) begin
      @(posedge clk);
      pass++;
    end
    repeat (2 * rhkv_pkg::TABLE_SIZE + 16) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("robin_hood_key_value_map_unit regression: pass");
    end else begin
      $display("robin_hood_key_value_map_unit regression: fail");
    end
    $finish;
  end

endmodule
